### hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pxsv_pkg.sv
// ----------------------------------------------------------------------------
// pxsv_pkg
// Types and constants of the peer transfer variable responder.
// ----------------------------------------------------------------------------
`default_nettype none

package pxsv_pkg;

   // request fields of one decoded peer transfer
   typedef struct packed {
      logic [6:0] source_low;
      logic [6:0] dest_low;
      logic [6:0] dest_high;
      logic [3:0] high_bits;
      logic [6:0] func;
      logic [6:0] var_index;
      logic [6:0] var_value;
   } req_type;

   // one reply byte
   typedef struct packed {
      logic [7:0] reply_byte;
      logic       last_byte;
   } rsp_type;

   // csr register indexes
   typedef enum logic [2:0] {
      REG_WRITE_CODE   = 3'd0,
      REG_READ_CODE    = 3'd1,
      REG_PORT_COUNT   = 3'd2,
      REG_VERSION_HIGH = 3'd3,
      REG_VERSION_LOW  = 3'd4
   } reg_idx_type;

   // reply frame constants
   localparam logic [7:0] OPC_PEER_XFER  = 8'hE5;
   localparam logic [7:0] MSG_LEN        = 8'h10;
   localparam logic [7:0] SRC_TAG        = 8'h7B;
   localparam logic [6:0] ADDR_PROG_HIGH = 7'h7F;
   localparam logic [7:0] ADDR_MASK_BYTE = 8'h7F;

   // reset values
   localparam logic [7:0] RST_WRITE_CODE = 8'd2;
   localparam logic [7:0] RST_READ_CODE  = 8'd1;
   localparam logic [6:0] RST_PORT_COUNT = 7'd2;
   localparam logic [7:0] RST_ADDR_LOW   = 8'd88;
   localparam logic [7:0] RST_ADDR_HIGH  = 8'd1;

   // reply byte positions
   localparam logic [3:0] POS_OPC    = 4'd0;
   localparam logic [3:0] POS_LEN    = 4'd1;
   localparam logic [3:0] POS_SRC    = 4'd2;
   localparam logic [3:0] POS_DST    = 4'd3;
   localparam logic [3:0] POS_SRCH   = 4'd4;
   localparam logic [3:0] POS_VERH   = 4'd5;
   localparam logic [3:0] POS_CMD    = 4'd6;
   localparam logic [3:0] POS_IDX    = 4'd7;
   localparam logic [3:0] POS_VERL   = 4'd8;
   localparam logic [3:0] POS_TAG    = 4'd9;
   localparam logic [3:0] POS_PXCT   = 4'd10;
   localparam logic [3:0] POS_D1     = 4'd11;
   localparam logic [3:0] POS_D2     = 4'd12;
   localparam logic [3:0] POS_D3     = 4'd13;
   localparam logic [3:0] POS_D4     = 4'd14;
   localparam logic [3:0] POS_CHK    = 4'd15;

   // width of a store index plus offset
   localparam int unsigned SUM_W = 9;

endpackage

`default_nettype wire

### hw/rtl/peer_xfer_sv_responder.sv
// ----------------------------------------------------------------------------
// peer_xfer_sv_responder
// Answers peer transfer variable requests from a variable store with one write and one read port.
// ----------------------------------------------------------------------------
// The first reply byte shows in the cycle after the accepting edge, and the other
// bytes of the 16-byte reply follow back to back.
// The next request is taken during the checksum byte, so a new request can be
// accepted before the reply to the last one ends. A rejected request gives no reply.
// Reset: a clearing pass writes zero to all STORE_DEPTH entries, one per cycle,
// with busy high; csr writes are taken meanwhile. The receiver cannot stall.
`default_nettype none

module peer_xfer_sv_responder
   import pxsv_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = 258
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   // reply channel
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   // csr port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned    ADDR_W    = $clog2(STORE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_LIM = SUM_W'(STORE_DEPTH);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   // csr registers
   logic [7:0] write_code_ff, write_code_in;
   logic [7:0] read_code_ff, read_code_in;
   logic [6:0] port_count_ff, port_count_in;
   logic [6:0] vers_high_ff, vers_high_in;
   logic [6:0] ver_low_ff, ver_low_in;

   // control state
   state_type         state_ff, state_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0]        own_low_ff, own_low_in;
   logic [7:0]        own_high_ff, own_high_in;

   // captured request and reply parts
   logic [6:0] src_ff, src_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] idx_ff, idx_in;
   logic       rd_ff, rd_in;
   logic [7:0] b10_ff, b10_in;
   logic [7:0] b11_ff, b11_in;
   logic [7:0] b14_ff, b14_in;
   logic [7:0] r0_ff, r0_in;
   logic [7:0] r1_ff, r1_in;
   logic [7:0] r2_ff, r2_in;
   logic [7:0] xor_ff, xor_in;

   // store and its ports
   logic [7:0]        store_mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              rd_ok_ff, rd_ok_in;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd;
   logic [SUM_W-1:0]  rd_addr;
   logic [7:0]        rd_word;

   // request decode
   logic             accept, take, addr_match;
   logic [7:0]       cmd8, idx8, val8;
   logic             is_wr, is_rd, wr_port, wr_in_range;
   logic [SUM_W-1:0] port_limit;
   logic             csr_wr;
   logic [7:0]       cur_byte;

   // ---------------------------------------------------------------- csr port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      write_code_in = write_code_ff;
      read_code_in  = read_code_ff;
      port_count_in = port_count_ff;
      vers_high_in  = vers_high_ff;
      ver_low_in    = ver_low_ff;
      if (csr_wr) begin
         unique case (paddr[4:2])
            REG_WRITE_CODE:   write_code_in = pwdata[7:0];
            REG_READ_CODE:    read_code_in  = pwdata[7:0];
            REG_PORT_COUNT:   port_count_in = pwdata[6:0];
            REG_VERSION_HIGH: vers_high_in  = pwdata[6:0];
            REG_VERSION_LOW:  ver_low_in    = pwdata[6:0];
            default: ;
         endcase
      end
   end

   // csr readback
   always_comb begin
      unique case (paddr[4:2])
         REG_WRITE_CODE:   prdata = {24'd0, write_code_ff};
         REG_READ_CODE:    prdata = {24'd0, read_code_ff};
         REG_PORT_COUNT:   prdata = {25'd0, port_count_ff};
         REG_VERSION_HIGH: prdata = {25'd0, vers_high_ff};
         REG_VERSION_LOW:  prdata = {25'd0, ver_low_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------- request decode
   assign busy   = (state_ff == ST_CLEAR) || ((state_ff == ST_SEND) && (cnt_ff != POS_CHK));
   assign accept = start & ~busy;

   assign addr_match = (({1'b0, req_data.dest_low} == own_low_ff) || (req_data.dest_low == 7'd0))
                    && (({1'b0, req_data.dest_high} == own_high_ff)
                        || (req_data.dest_high == ADDR_PROG_HIGH));
   assign take = accept & addr_match;

   // restore bit 7 of the command, index and value bytes
   assign cmd8 = {req_data.high_bits[0], req_data.func};
   assign idx8 = {req_data.high_bits[1], req_data.var_index};
   assign val8 = {req_data.high_bits[3], req_data.var_value};

   assign is_wr       = (cmd8 == write_code_ff);
   assign is_rd       = (cmd8 == read_code_ff) || (cmd8 == 8'd0);
   assign port_limit  = ({2'b00, port_count_ff} << 1) + {2'b00, port_count_ff} + SUM_W'(3);
   assign wr_port     = is_wr && (idx8 > 8'd2) && ({1'b0, idx8} < port_limit);
   assign wr_in_range = ({1'b0, idx8} < DEPTH_LIM);

   // write-side reply parts and address updates
   always_comb begin
      own_low_in  = own_low_ff;
      own_high_in = own_high_ff;
      b10_in      = b10_ff;
      b11_in      = b11_ff;
      b14_in      = b14_ff;
      if (take) begin
         b10_in = 8'd0;
         b11_in = 8'd0;
         b14_in = 8'd0;
         if (is_wr) begin
            priority if (idx8 == 8'd0) begin
               b11_in = own_high_ff;
            end else if (idx8 == 8'd1) begin
               own_low_in = val8;
               b11_in     = ADDR_MASK_BYTE;
               b14_in     = val8;
            end else if (idx8 == 8'd2) begin
               if (val8 != ADDR_MASK_BYTE) begin
                  own_high_in = val8;
               end
               b11_in = ADDR_MASK_BYTE;
               b14_in = ADDR_MASK_BYTE;
            end else if (wr_port) begin
               // read-back equals the written value unless the index is off the store
               b11_in = own_high_ff;
               if (wr_in_range) begin
                  b10_in = {4'd0, val8[7], 3'd0};
                  b14_in = {1'b0, val8[6:0]};
               end
            end else begin
               // beyond the port range the data bytes stay zero
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               state_in = ST_SEND;
               cnt_in   = 4'd0;
            end
         end
         ST_SEND: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == POS_CHK) begin
               state_in = take ? ST_SEND : ST_IDLE;
               cnt_in   = 4'd0;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // request capture
   always_comb begin
      src_in = take ? req_data.source_low : src_ff;
      cmd_in = take ? cmd8 : cmd_ff;
      idx_in = take ? idx8 : idx_ff;
      rd_in  = take ? is_rd : rd_ff;
   end

   // ------------------------------------------------------------ store access
   // writes: clearing pass, or a port variable write on the accepting edge
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = 8'd0;
      end else begin
         mem_we = take & wr_port & wr_in_range;
         mem_wa = idx8[ADDR_W-1:0];
         mem_wd = val8;
      end
   end

   // reads of index, index+1, index+2 while reply bytes 0 to 2 go out
   assign rd_addr  = {1'b0, idx_ff} + {{(SUM_W-2){1'b0}}, cnt_ff[1:0]};
   assign rd_ok_in = (rd_addr < DEPTH_LIM);
   assign mem_re   = (state_ff == ST_SEND) && rd_ff && (cnt_ff < 4'd3) && rd_ok_in;
   assign mem_ra   = rd_addr[ADDR_W-1:0];
   assign rd_word  = rd_ok_ff ? rd_data_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_ra];
      end
   end

   // collect the read words in the cycle after each read
   always_comb begin
      r0_in = r0_ff;
      r1_in = r1_ff;
      r2_in = r2_ff;
      if (state_ff == ST_SEND) begin
         if (cnt_ff == 4'd1) r0_in = rd_word;
         if (cnt_ff == 4'd2) r1_in = rd_word;
         if (cnt_ff == 4'd3) r2_in = rd_word;
      end
   end

   // ------------------------------------------------------------- reply bytes
   always_comb begin
      unique case (cnt_ff)
         POS_OPC:  cur_byte = OPC_PEER_XFER;
         POS_LEN:  cur_byte = MSG_LEN;
         POS_SRC:  cur_byte = own_low_ff;
         POS_DST:  cur_byte = {1'b0, src_ff};
         POS_SRCH: cur_byte = own_high_ff;
         POS_VERH: cur_byte = {1'b0, vers_high_ff};
         POS_CMD:  cur_byte = cmd_ff;
         POS_IDX:  cur_byte = idx_ff;
         POS_VERL: cur_byte = {1'b0, ver_low_ff};
         POS_TAG:  cur_byte = SRC_TAG;
         POS_PXCT: cur_byte = b10_ff
                              | (rd_ff ? {4'd0, r2_ff[7], r1_ff[7], r0_ff[7], 1'b0} : 8'd0);
         POS_D1:   cur_byte = rd_ff ? 8'd1 : b11_ff;
         POS_D2:   cur_byte = rd_ff ? {1'b0, r0_ff[6:0]} : 8'd0;
         POS_D3:   cur_byte = rd_ff ? {1'b0, r1_ff[6:0]} : 8'd0;
         POS_D4:   cur_byte = rd_ff ? {1'b0, r2_ff[6:0]} : b14_ff;
         POS_CHK:  cur_byte = ~xor_ff;
         default:  cur_byte = 8'd0;
      endcase
   end

   // running checksum over bytes 0 to 14
   always_comb begin
      priority if (take) begin
         xor_in = 8'd0;
      end else if (state_ff == ST_SEND) begin
         xor_in = xor_ff ^ cur_byte;
      end else begin
         xor_in = xor_ff;
      end
   end

   assign rsp_valid           = (state_ff == ST_SEND);
   assign rsp_data.reply_byte = cur_byte;
   assign rsp_data.last_byte  = (state_ff == ST_SEND) && (cnt_ff == POS_CHK);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_code_ff <= RST_WRITE_CODE;
         read_code_ff  <= RST_READ_CODE;
         port_count_ff <= RST_PORT_COUNT;
         vers_high_ff  <= 7'd0;
         ver_low_ff    <= 7'd0;
         state_ff      <= ST_CLEAR;
         cnt_ff        <= 4'd0;
         clr_cnt_ff    <= '0;
         own_low_ff    <= RST_ADDR_LOW;
         own_high_ff   <= RST_ADDR_HIGH;
      end else begin
         write_code_ff <= write_code_in;
         read_code_ff  <= read_code_in;
         port_count_ff <= port_count_in;
         vers_high_ff  <= vers_high_in;
         ver_low_ff    <= ver_low_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         clr_cnt_ff    <= clr_cnt_in;
         own_low_ff    <= own_low_in;
         own_high_ff   <= own_high_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      rd_ff    <= rd_in;
      b10_ff   <= b10_in;
      b11_ff   <= b11_in;
      b14_ff   <= b14_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      xor_ff   <= xor_in;
      rd_ok_ff <= rd_ok_in;
   end

endmodule

`default_nettype wire

### hw/rtl/pxsv_checker.sv
// ----------------------------------------------------------------------------
// pxsv_checker
// Port-level checks of the responder's reply framing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pxsv_checker
   import pxsv_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire rsp_type     rsp_data
);

   // a reply is sent without gaps up to its checksum
   `ASSERT_NEXT(a_reply_contiguous, clock, reset, rsp_valid && !rsp_data.last_byte, rsp_valid, "reply broken before checksum")

   // no request transfer is taken in the middle of a reply
   `ASSERT_SAME(a_busy_in_reply, clock, reset, rsp_valid && !rsp_data.last_byte, busy, "request taken during reply")

   // the checksum flag only comes with a strobed byte
   `ASSERT_SAME(a_last_valid, clock, reset, rsp_data.last_byte, rsp_valid, "checksum flag without strobe")

   // every reply opens with the peer transfer opcode
   `ASSERT_SAME(a_reply_opcode, clock, reset, rsp_valid && (!$past(rsp_valid) || $past(rsp_data.last_byte)), rsp_data.reply_byte == OPC_PEER_XFER, "reply does not open with opcode")

endmodule

bind peer_xfer_sv_responder pxsv_checker u_pxsv_checker (.*);

`default_nettype wire
